// ===== design/spi_pkg.sv =====
package spi_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;
    localparam logic [1:0] REG_COEF_D = 2'd3;

    // Width of the plane numerator and denominator sums (signed).
    localparam int NUM_W = 50;
    localparam int DEN_W = 51;
    // Width of the divider operand magnitudes and of its partial remainder.
    localparam int MAG_W = 50;
    localparam int REM_W = MAG_W + 31;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // First point and segment direction, carried alongside the arithmetic.
    typedef struct packed {
        logic [2:0][31:0] p0;
        logic [2:0][32:0] dv;
    } geo_t;

endpackage

// ===== design/spi_dot.sv =====
module spi_dot
    import spi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][31:0]        p0,
    input  logic [2:0][31:0]        p1,
    input  logic [31:0]             coef_a,
    input  logic [31:0]             coef_b,
    input  logic [31:0]             coef_c,
    input  logic [31:0]             coef_d,
    output logic                    out_valid,
    output logic signed [NUM_W-1:0] num,
    output logic signed [DEN_W-1:0] den,
    output geo_t                    geo
);

    logic [2:0][31:0]        coef;
    logic                    va_reg;
    logic                    vb_reg;
    logic                    vc_reg;
    geo_t                    geo_a_reg;
    geo_t                    geo_b_reg;
    geo_t                    geo_c_reg;
    geo_t                    geo_a_next;
    logic signed [63:0]      pp [3];
    logic signed [64:0]      dp [3];
    logic signed [47:0]      np_reg [3];
    logic signed [48:0]      dq_reg [3];
    logic signed [NUM_W-1:0] num_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic signed [NUM_W-1:0] num_next;
    logic signed [DEN_W-1:0] den_next;

    assign coef = {coef_c, coef_b, coef_a};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            geo_a_next.p0[i] = p0[i];
            geo_a_next.dv[i] = 33'($signed({p1[i][31], p1[i]}) - $signed({p0[i][31], p0[i]}));
        end
    end

    // Exact products, floored to Q16.16 by dropping the low 16 bits.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pp[i] = $signed(coef[i]) * $signed(geo_a_reg.p0[i]);
            dp[i] = $signed(coef[i]) * $signed(geo_a_reg.dv[i]);
        end
    end

    always_comb
    begin
        num_next = NUM_W'(np_reg[0]) + NUM_W'(np_reg[1]) + NUM_W'(np_reg[2])
                 + NUM_W'($signed(coef_d));
        den_next = DEN_W'(dq_reg[0]) + DEN_W'(dq_reg[1]) + DEN_W'(dq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_a_reg <= geo_a_next;
            geo_b_reg <= geo_a_reg;
            geo_c_reg <= geo_b_reg;
            for (int i = 0; i < 3; i++)
            begin
                np_reg[i] <= pp[i][63:16];
                dq_reg[i] <= dp[i][64:16];
            end
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign out_valid = vc_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign geo       = geo_c_reg;

endmodule

// ===== design/spi_div.sv =====
module spi_div
    import spi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    input  geo_t                    in_geo,
    output logic                    out_valid,
    output logic [31:0]             t,
    output logic                    hit,
    output geo_t                    out_geo
);

    typedef struct packed {
        logic neg;
        logic ovf;
        logic zero;
    } dflag_t;

    logic [MAG_W-1:0] mn;
    logic [MAG_W-1:0] md;
    dflag_t           fl_next;

    logic             v_reg   [0:31];
    logic [REM_W-1:0] rem_reg [0:31];
    logic [MAG_W-1:0] md_reg  [0:31];
    logic [30:0]      q_reg   [0:31];
    dflag_t           fl_reg  [0:31];
    geo_t             geo_reg [0:31];

    logic             vo_reg;
    logic [31:0]      t_reg;
    logic             hit_reg;
    geo_t             geo_o_reg;
    logic [31:0]      t_next;

    // t = -num / den, so the quotient is negative when num and den agree in sign.
    always_comb
    begin
        mn = MAG_W'(num[NUM_W-1] ? -num : num);
        md = MAG_W'(den[DEN_W-1] ? -den : den);
        fl_next.neg  = (!num[NUM_W-1] && (num != '0)) ^ den[DEN_W-1];
        fl_next.zero = (den == '0);
        fl_next.ovf  = (REM_W'(mn) >= (REM_W'(md) << 15));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(mn) << 16;
            md_reg[0]  <= md;
            q_reg[0]   <= '0;
            fl_reg[0]  <= fl_next;
            geo_reg[0] <= in_geo;
        end
    end

    // One restoring step per stage, quotient bit 30 down to bit 0.
    for (genvar k = 0; k < 31; k++)
    begin : g_step
        logic [REM_W-1:0] sh;
        logic             ge;
        logic [30:0]      q_next;

        always_comb
        begin
            sh            = REM_W'(md_reg[k]) << (30 - k);
            ge            = (rem_reg[k] >= sh);
            q_next        = q_reg[k];
            q_next[30 - k] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k + 1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k + 1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k + 1] <= ge ? (rem_reg[k] - sh) : rem_reg[k];
                md_reg[k + 1]  <= md_reg[k];
                q_reg[k + 1]   <= q_next;
                fl_reg[k + 1]  <= fl_reg[k];
                geo_reg[k + 1] <= geo_reg[k];
            end
        end
    end

    always_comb
    begin
        if (fl_reg[31].zero)
        begin
            t_next = '0;
        end
        else if (fl_reg[31].ovf)
        begin
            t_next = fl_reg[31].neg ? S32_MIN : S32_MAX;
        end
        else
        begin
            t_next = fl_reg[31].neg ? -{1'b0, q_reg[31]} : {1'b0, q_reg[31]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= v_reg[31];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next;
            hit_reg   <= !fl_reg[31].zero;
            geo_o_reg <= geo_reg[31];
        end
    end

    assign out_valid = vo_reg;
    assign t         = t_reg;
    assign hit       = hit_reg;
    assign out_geo   = geo_o_reg;

    // Without overflow the whole quotient fits in 31 bits.
    a_rem_fits: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !fl_reg[0].zero && !fl_reg[0].ovf
            |-> rem_reg[0] < (REM_W'(md_reg[0]) << 31))
        else $error("divider operand exceeds quotient range");

endmodule

// ===== design/spi_point.sv =====
module spi_point
    import spi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [31:0]      t,
    input  logic             hit,
    input  geo_t             geo,
    output logic             out_valid,
    output logic [2:0][31:0] cross_pt,
    output logic [31:0]      ratio_t,
    output logic             out_hit
);

    logic               vm_reg;
    logic               vs_reg;
    logic [31:0]        tm_reg;
    logic               hm_reg;
    logic [2:0][31:0]   p0m_reg;
    logic signed [48:0] fl_reg [3];
    logic signed [64:0] prod [3];
    logic signed [49:0] sum [3];
    logic [2:0][31:0]   cross_next;
    logic [2:0][31:0]   cross_reg;
    logic [31:0]        ts_reg;
    logic               hs_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = $signed(t) * $signed(geo.dv[i]);
        end
    end

    // A miss carries t = 0, so the sum falls back to the first point by itself.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = 50'($signed(p0m_reg[i])) + 50'(fl_reg[i]);
            if (sum[i] > 50'(S32_MAX))
            begin
                cross_next[i] = S32_MAX;
            end
            else if (sum[i] < 50'(S32_MIN))
            begin
                cross_next[i] = S32_MIN;
            end
            else
            begin
                cross_next[i] = sum[i][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vs_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= in_valid;
            vs_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fl_reg[i] <= prod[i][64:16];
            end
            p0m_reg   <= geo.p0;
            tm_reg    <= t;
            hm_reg    <= hit;
            cross_reg <= cross_next;
            ts_reg    <= tm_reg;
            hs_reg    <= hm_reg;
        end
    end

    assign out_valid = vs_reg;
    assign cross_pt  = cross_reg;
    assign ratio_t   = ts_reg;
    assign out_hit   = hs_reg;

endmodule

// ===== design/segment_plane_intersection_core.sv =====
// Line / plane intersection in signed Q16.16 fixed point.
// The plane a*x + b*y + c*z + d = 0 is loaded through the write port
// (cfg_we, cfg_index 0..3 for a, b, c, d, cfg_data) while the block is idle.
// Each input word on the s_ channel carries two points P0 and P1; the block
// returns on the m_ channel the intersection of the line through them with
// the plane, the line parameter t and a hit flag (0 for a parallel line, in
// which case the point is P0 and t is 0). Results saturate to 32 bits.
// The pipeline is 38 stages deep: 3 for the dot products, 33 for the
// radix-2 divider (one quotient bit per step stage) and 2 for the point
// multiply and add. A word may enter every cycle while the output is not
// stalled, so throughput is one word per clock. All stages advance
// together; when m_tvalid is high and m_tready low, the whole pipeline
// holds, s_tready drops and no word is lost or repeated.
// Reset clears all valid bits and the plane registers to zero.
module segment_plane_intersection_core
    import spi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z from the lowest bit up
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cross_x, cross_y, cross_z, ratio_t from the lowest bit up
    output logic [127:0] m_tdata,
    // hit
    output logic [0:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [31:0]             coef_a_reg;
    logic [31:0]             coef_b_reg;
    logic [31:0]             coef_c_reg;
    logic [31:0]             coef_d_reg;
    logic                    adv;
    logic [2:0][31:0]        p0;
    logic [2:0][31:0]        p1;
    logic                    dot_valid;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    geo_t                    dot_geo;
    logic                    div_valid;
    logic [31:0]             div_t;
    logic                    div_hit;
    geo_t                    div_geo;
    logic [2:0][31:0]        cross_pt;
    logic [31:0]             ratio_t;
    logic                    hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_A: coef_a_reg <= cfg_data;
                REG_COEF_B: coef_b_reg <= cfg_data;
                REG_COEF_C: coef_c_reg <= cfg_data;
                REG_COEF_D: coef_d_reg <= cfg_data;
                default:    coef_a_reg <= coef_a_reg;
            endcase
        end
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    assign p0 = s_tdata[95:0];
    assign p1 = s_tdata[191:96];

    spi_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .p0        (p0),
        .p1        (p1),
        .coef_a    (coef_a_reg),
        .coef_b    (coef_b_reg),
        .coef_c    (coef_c_reg),
        .coef_d    (coef_d_reg),
        .out_valid (dot_valid),
        .num       (num),
        .den       (den),
        .geo       (dot_geo)
    );

    spi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (dot_valid),
        .num       (num),
        .den       (den),
        .in_geo    (dot_geo),
        .out_valid (div_valid),
        .t         (div_t),
        .hit       (div_hit),
        .out_geo   (div_geo)
    );

    spi_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (div_valid),
        .t         (div_t),
        .hit       (div_hit),
        .geo       (div_geo),
        .out_valid (m_tvalid),
        .cross_pt  (cross_pt),
        .ratio_t   (ratio_t),
        .out_hit   (hit)
    );

    assign m_tdata = {ratio_t, cross_pt};
    assign m_tuser = hit;

    // A parallel line always reports a zero parameter.
    a_miss_zero_t: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[127:96] == 32'd0)
        else $error("miss with nonzero ratio_t");

    // A held result must stop intake, or a word would be dropped inside.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

endmodule

// ===== dv/segment_plane_intersection_core_tb.sv =====
module segment_plane_intersection_core_tb;
    import spi_pkg::*;

    // One result word as the block presents it: the crossing point, the line
    // parameter and the hit flag.
    typedef struct packed {
        logic [31:0] cross_x;
        logic [31:0] cross_y;
        logic [31:0] cross_z;
        logic [31:0] ratio_t;
        logic        hit;
    } crossing_t;

    localparam int CYCLE_LIMIT = 400000;
    // Pipeline depth given at the head of the block, plus some margin.
    localparam int SETTLE_CYCLES = 50;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // Our own copy of the plane registers, updated on every write.
    logic signed [31:0] plane_a;
    logic signed [31:0] plane_b;
    logic signed [31:0] plane_c;
    logic signed [31:0] plane_d;

    // Crossings predicted for accepted words, oldest first.
    crossing_t pending_crossings[$];

    int error_count;
    int cycle_count = 0;
    int sender_idle_pct;
    int receiver_stall_pct;

    segment_plane_intersection_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Saturate a wide signed value to the 32 bit signed range.
    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF)
            return S32_MAX;
        if (v < -128'sh8000_0000)
            return S32_MIN;
        return v[31:0];
    endfunction

    // Predict the crossing of the line P0->P1 with the current plane. Every
    // product is exact and then floored to Q16.16 by an arithmetic shift.
    function automatic crossing_t predict_crossing(input logic [191:0] w);
        logic signed [127:0] p0[3];
        logic signed [127:0] dv[3];
        logic signed [127:0] na, nb, nc, nd;
        logic signed [127:0] num, den, quo;
        logic [31:0]         t_sat;
        crossing_t           r;
        for (int i = 0; i < 3; i++) begin
            p0[i] = $signed(w[32*i +: 32]);
            dv[i] = $signed(w[32*(i+3) +: 32]) - p0[i];
        end
        na = plane_a;
        nb = plane_b;
        nc = plane_c;
        nd = plane_d;
        num = ((na * p0[0]) >>> 16) + ((nb * p0[1]) >>> 16)
            + ((nc * p0[2]) >>> 16) + nd;
        den = ((na * dv[0]) >>> 16) + ((nb * dv[1]) >>> 16)
            + ((nc * dv[2]) >>> 16);
        if (den == 0) begin
            // Parallel line: the point stays at P0 and t is zero.
            r.cross_x = p0[0][31:0];
            r.cross_y = p0[1][31:0];
            r.cross_z = p0[2][31:0];
            r.ratio_t = '0;
            r.hit     = 1'b0;
            return r;
        end
        // Signed division truncates toward zero, as the block does.
        quo   = ((-num) <<< 16) / den;
        t_sat = clamp32(quo);
        r.cross_x = clamp32(p0[0] + (($signed(t_sat) * dv[0]) >>> 16));
        r.cross_y = clamp32(p0[1] + (($signed(t_sat) * dv[1]) >>> 16));
        r.cross_z = clamp32(p0[2] + (($signed(t_sat) * dv[2]) >>> 16));
        r.ratio_t = t_sat;
        r.hit     = 1'b1;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at cycle %0d",
                 field, got, want, cycle_count);
        error_count++;
    endtask

    // Result checker: each word taken from the master side is compared with
    // the oldest prediction.
    always @(posedge clk) begin
        crossing_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_crossings.size() == 0) begin
                note_mismatch("unexpected result word", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_crossings.pop_front();
                if (m_tdata[31:0] !== want.cross_x)
                    note_mismatch("cross_x", m_tdata[31:0], want.cross_x);
                if (m_tdata[63:32] !== want.cross_y)
                    note_mismatch("cross_y", m_tdata[63:32], want.cross_y);
                if (m_tdata[95:64] !== want.cross_z)
                    note_mismatch("cross_z", m_tdata[95:64], want.cross_z);
                if (m_tdata[127:96] !== want.ratio_t)
                    note_mismatch("ratio_t", m_tdata[127:96], want.ratio_t);
                if (m_tuser[0] !== want.hit)
                    note_mismatch("hit", {31'd0, m_tuser[0]}, {31'd0, want.hit});
            end
        end
    end

    // The receiver stalls at random, at the rate the current phase sets.
    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // A run that hangs is stopped here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Write one plane register. Called at a falling edge, returns at one.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_COEF_A: plane_a = value;
            REG_COEF_B: plane_b = value;
            REG_COEF_C: plane_c = value;
            default:    plane_d = value;
        endcase
    endtask

    // Wait for every predicted word to come back, then let the pipeline settle
    // so the block is idle.
    task automatic drain_pipeline;
        s_tvalid <= 1'b0;
        while (pending_crossings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_plane(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d);
        drain_pipeline();
        write_register(REG_COEF_A, a);
        write_register(REG_COEF_B, b);
        write_register(REG_COEF_C, c);
        write_register(REG_COEF_D, d);
    endtask

    // Offer one segment word and wait until it is taken. Entered and left at a
    // falling edge; s_tvalid stays high between words unless a gap is drawn.
    task automatic send_segment(input logic [31:0] p0x, input logic [31:0] p0y,
                                input logic [31:0] p0z, input logic [31:0] p1x,
                                input logic [31:0] p1y, input logic [31:0] p1z);
        logic [191:0] w;
        w = {p1z, p1y, p1x, p0z, p0y, p0x};
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(posedge clk);
        while (!s_tready);
        pending_crossings.push_back(predict_crossing(w));
        @(negedge clk);
    endtask

    // Random Q16.16 value: mostly moderate magnitudes, sometimes full range
    // or an extreme.
    function automatic logic [31:0] rand_q;
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return $urandom_range(1) ? S32_MAX : S32_MIN;
            2:       return $signed($urandom_range(65535)) - 32768;
            default: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    // Right after reset the normal is all zero, so every line is parallel.
    task automatic test_reset_plane;
        send_segment(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                     32'h0004_0000, 32'h0005_0000, 32'h0006_0000);
        send_segment(S32_MAX, S32_MIN, 32'h0, S32_MIN, S32_MAX, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed;
        // Plane x = 2.0.
        load_plane(32'h0001_0000, 32'h0, 32'h0, 32'hFFFE_0000);
        send_segment(32'h0, 32'h0001_0000, 32'h0, 32'h0004_0000, 32'h0001_0000, 32'h0);
        send_segment(32'h0003_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0);
        // Degenerate segment and a segment inside a plane-parallel direction.
        send_segment(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                     32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_segment(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0009_0000, 32'h0005_0000);
        // A one-LSB step in x against a big offset gives a huge t of each sign.
        load_plane(32'h0001_0000, 32'h0, 32'h0, 32'h1000_0000);
        send_segment(32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
        send_segment(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
        // Extremes of every point field.
        send_segment(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN);
        send_segment(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX);
        // Extreme plane coefficients.
        load_plane(S32_MIN, S32_MAX, S32_MIN, S32_MAX);
        send_segment(S32_MAX, S32_MIN, 32'h0, S32_MIN, S32_MAX, 32'hFFFF_FFFF);
        send_segment(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
                     32'h0, 32'h0, 32'h0);
        send_segment(S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MAX);
        load_plane(S32_MAX, S32_MAX, S32_MAX, S32_MIN);
        send_segment(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_segment(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN);
    endtask

    // Random segments against a fixed plane. Some share a coordinate with P0
    // along an axis normal, or repeat P0, to hit the parallel case often.
    task automatic test_random_segments(input int count);
        logic [31:0] p[6];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 6; i++)
                p[i] = rand_q();
            case ($urandom_range(9))
                0: for (int i = 0; i < 3; i++) p[i+3] = p[i];
                1: p[3] = p[0];
                default: ;
            endcase
            send_segment(p[0], p[1], p[2], p[3], p[4], p[5]);
        end
    endtask

    task automatic test_random_phase(input int count);
        // Several planes per phase: random, axis-aligned and tiny normals.
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: load_plane(rand_q(), rand_q(), rand_q(), rand_q());
                1: load_plane(32'h0001_0000, 32'h0, 32'h0, rand_q());
                2: load_plane($urandom_range(3), $urandom_range(3), 32'h0, $urandom());
                default: load_plane($urandom(), $urandom(), $urandom(), $urandom());
            endcase
            test_random_segments(count / 4);
        end
    endtask

    initial begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        m_tready           = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_COEF_A;
        cfg_data           = '0;
        plane_a            = '0;
        plane_b            = '0;
        plane_c            = '0;
        plane_d            = '0;
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_plane();
        test_directed();

        // Mostly stalling receiver with a busier sender, then the reverse, then
        // back-to-back words with no idling at all.
        sender_idle_pct    = 35;
        receiver_stall_pct = 75;
        test_random_phase(160);
        sender_idle_pct    = 75;
        receiver_stall_pct = 35;
        test_random_phase(160);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_phase(180);

        drain_pipeline();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
